// ===== rtl/core/qfs_pkg.sv =====
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared types and constants of the quoted field splitter.
// ----------------------------------------------------------------------------
package qfs_pkg;

	localparam int OUT_BITS     = 16;
	localparam int COUNT_BITS   = 16;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SEPARATOR = 2'd0,
		REG_QUOTE     = 2'd1
	} cfg_reg_t;

	// One result item
	typedef struct packed {
		logic                  char_valid;
		logic [OUT_BITS-1:0]   out_char;
		logic                  field_end;
		logic                  line_end;
		logic [COUNT_BITS-1:0] field_count;
	} result_t;

endpackage

// ===== rtl/core/quoted_field_splitter.sv =====
// ----------------------------------------------------------------------------
// quoted_field_splitter
// Splits a character stream into fields at a separator, honoring quoted
// fields with doubled-quote escapes.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | sink      | in_valid / in_stall  | in_char, line_last
//  out     | source    | out_valid / out_stall| char_valid, out_char, field_end,
//          |           |                      | line_end, field_count
//  cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
//  Each item passes through the input register and then the result
//  register; one item per cycle is sustained while out_stall is low.
//  The line state flags update in the same cycle an item moves from the
//  input register into the result register, so one character per clock
//  is the limit set by that single classification step.
//  Reset clears both stages, the line state and the configuration
//  registers (separator 44, quote 34).
//  out_stall backs up into in_stall combinationally only when both stages
//  hold an item; otherwise a new item enters while a result waits.
// ----------------------------------------------------------------------------
module quoted_field_splitter import qfs_pkg::*; #(
	parameter int CHAR_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CHAR_BITS-1:0]    cfg_wdata,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CHAR_BITS-1:0]    in_char,
	input  logic                    line_last,

	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    char_valid,
	output logic [OUT_BITS-1:0]     out_char,
	output logic                    field_end,
	output logic                    line_end,
	output logic [COUNT_BITS-1:0]   field_count
);

	logic [CHAR_BITS-1:0] separator_q;
	logic [CHAR_BITS-1:0] quote_q;

	// Input register
	logic                 valid_s1;
	logic [CHAR_BITS-1:0] char_s1;
	logic                 last_s1;

	// Result register
	logic                 valid_s2;
	result_t              result_s2;

	result_t              step_result;
	logic                 s2_free;
	logic                 advance;
	logic                 accept;

	qfs_cfg #(
		.CHAR_BITS (CHAR_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.separator_q (separator_q),
		.quote_q     (quote_q)
	);

	// The result register can take a new item when empty or being drained
	assign s2_free  = !valid_s2 || !out_stall;
	// Move the held item into the result register and commit its state
	assign advance  = valid_s1 && s2_free;
	// Hold the input side only when the input register cannot empty
	assign in_stall = valid_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	qfs_step #(
		.CHAR_BITS (CHAR_BITS)
	) u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.in_char        (char_s1),
		.line_last      (last_s1),
		.separator_char (separator_q),
		.quote_char     (quote_q),
		.result         (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= in_char;
			last_s1 <= line_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign out_valid   = valid_s2;
	assign char_valid  = result_s2.char_valid;
	assign out_char    = result_s2.out_char;
	assign field_end   = result_s2.field_end;
	assign line_end    = result_s2.line_end;
	assign field_count = result_s2.field_count;

endmodule

// ===== rtl/core/qfs_cfg.sv =====
// ----------------------------------------------------------------------------
// qfs_cfg
// Separator and quote character registers behind the write port.
// ----------------------------------------------------------------------------
module qfs_cfg import qfs_pkg::*; #(
	parameter int CHAR_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CHAR_BITS-1:0]    cfg_wdata,
	output logic [CHAR_BITS-1:0]    separator_q,
	output logic [CHAR_BITS-1:0]    quote_q
);

	localparam logic [CHAR_BITS-1:0] SEP_RESET   = CHAR_BITS'(44);
	localparam logic [CHAR_BITS-1:0] QUOTE_RESET = CHAR_BITS'(34);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q <= SEP_RESET;
			quote_q     <= QUOTE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEPARATOR: separator_q <= cfg_wdata;
				REG_QUOTE:     quote_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/qfs_step.sv =====
// ----------------------------------------------------------------------------
// qfs_step
// Line state flags, field counter and the per-character classification.
// ----------------------------------------------------------------------------
module qfs_step import qfs_pkg::*; #(
	parameter int CHAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [CHAR_BITS-1:0] in_char,
	input  logic                 line_last,
	input  logic [CHAR_BITS-1:0] separator_char,
	input  logic [CHAR_BITS-1:0] quote_char,
	output result_t              result
);

	logic                  at_start_q;
	logic                  in_quotes_q;
	logic                  pending_q;
	logic [COUNT_BITS-1:0] seen_q;

	logic                  at_start_d;
	logic                  in_quotes_d;
	logic                  pending_d;
	logic [COUNT_BITS-1:0] seen_d;

	logic                  is_quote;
	logic                  is_sep;
	logic                  valid;
	logic                  fend;
	logic                  done;
	logic [OUT_BITS+CHAR_BITS-1:0] char_wide;

	assign is_quote  = (in_char == quote_char);
	assign is_sep    = (in_char == separator_char);
	assign char_wide = {{OUT_BITS{1'b0}}, in_char};

	always_comb begin
		at_start_d  = at_start_q;
		in_quotes_d = in_quotes_q;
		pending_d   = pending_q;
		seen_d      = seen_q;
		valid       = 1'b0;
		fend        = 1'b0;
		done        = 1'b0;

		// Resolve a held quote, or open a quoted field
		if (pending_q) begin
			pending_d = 1'b0;
			if (is_quote) begin
				valid = 1'b1;
				done  = 1'b1;
			end else begin
				in_quotes_d = 1'b0;
			end
		end else if (at_start_q) begin
			at_start_d = 1'b0;
			if (is_quote) begin
				in_quotes_d = 1'b1;
				done        = 1'b1;
			end
		end

		if (!done) begin
			if (in_quotes_d) begin
				if (is_quote) begin
					pending_d = 1'b1;
				end else begin
					valid = 1'b1;
				end
			end else if (is_sep) begin
				fend       = 1'b1;
				at_start_d = 1'b1;
				if (seen_q != COUNT_MAX) begin
					seen_d = seen_q + 1'b1;
				end
			end else begin
				valid = 1'b1;
			end
		end

		result.char_valid  = valid;
		result.out_char    = valid ? char_wide[OUT_BITS-1:0] : '0;
		result.field_end   = fend | line_last;
		result.line_end    = line_last;
		result.field_count = (seen_d == COUNT_MAX) ? COUNT_MAX : seen_d + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q  <= 1'b1;
			in_quotes_q <= 1'b0;
			pending_q   <= 1'b0;
			seen_q      <= '0;
		end else if (advance) begin
			if (line_last) begin
				at_start_q  <= 1'b1;
				in_quotes_q <= 1'b0;
				pending_q   <= 1'b0;
				seen_q      <= '0;
			end else begin
				at_start_q  <= at_start_d;
				in_quotes_q <= in_quotes_d;
				pending_q   <= pending_d;
				seen_q      <= seen_d;
			end
		end
	end

endmodule
